// File: sv/hptp_pkg.sv
// Shared types, character codes and helpers for the host:port text parser.
package hptp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [15:0] NUM_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_ADDR   = 3'd1,
		PH_SEEK   = 3'd2,
		PH_PORT   = 3'd3,
		PH_EXTRA  = 3'd4,
		PH_IGNORE = 3'd5
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] extra;
		logic [1:0]  seen;   // bit0 port field, bit1 extra field
	} parse_state_t;

	typedef struct packed {
		logic [31:0] host_address;
		logic [15:0] port_number;
		logic [15:0] extra_number;
		logic [2:0]  found_flags;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc*10 + digit, clamped to 16 bits
	function automatic logic [15:0] sat_mac(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		v = 20'(acc) * 20'd10 + 20'(c[3:0]);
		return (v > 20'(NUM_MAX)) ? NUM_MAX : v[15:0];
	endfunction

endpackage

// File: sv/hptp_ifs.sv
// Channel interfaces: character input, parse result output, configuration write.
interface hptp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface hptp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] host_address;
	logic [15:0] port_number;
	logic [15:0] extra_number;
	logic [2:0]  found_flags;
	modport source (output valid, output host_address, output port_number,
		output extra_number, output found_flags, input ready);
	modport sink (input valid, input host_address, input port_number,
		input extra_number, input found_flags, output ready);
endinterface

interface hptp_cfg_if;
	logic valid;
	logic ready;
	logic extra_field_enabled;
	modport source (output valid, output extra_field_enabled, input ready);
	modport sink (input valid, input extra_field_enabled, output ready);
endinterface

// File: sv/host_port_text_parser.sv
// Host:port[:extra] text parser, one character per item.
// The result of a terminating zero byte passes through the input register and then the result register.
// Throughput: one character per cycle; the input register holds a zero byte only
// while the result register still holds an untaken result.
// Reset clears the parser state to the skip phase, empties both registers and sets
// the extra field enable.
module host_port_text_parser import hptp_pkg::*; (
	input logic clk,
	input logic arst_n,
	hptp_char_if.sink     char_chan,
	hptp_result_if.source result_chan,
	hptp_cfg_if.sink      cfg_chan
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res;
	logic         fire;
	logic         out_free;
	logic         go_s1;
	logic         extra_en_q;
	logic         accept;

	assign cfg_chan.ready  = 1'b1;
	assign go_s1           = valid_s1 && (!fire || out_free);
	assign char_chan.ready = !valid_s1 || go_s1;
	assign accept          = char_chan.valid && char_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_en_q <= 1'b1;
		end else if (cfg_chan.valid) begin
			extra_en_q <= cfg_chan.extra_field_enabled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !go_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_chan.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SKIP, addr: '0, port: '0, extra: '0, seen: '0};
		end else if (go_s1) begin
			state_q <= state_nxt;
		end
	end

	hptp_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.extra_en  (extra_en_q),
		.nxt       (state_nxt),
		.res       (res),
		.fire      (fire)
	);

	hptp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (go_s1 && fire),
		.res         (res),
		.free        (out_free),
		.result_chan (result_chan)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_chan.valid && !result_chan.ready) |-> !(go_s1 && fire))
		else $error("result register overwritten while held");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && fire) |=> (state_q.phase == PH_SKIP && state_q.seen == 2'b00))
		else $error("parser did not restart after terminator");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_chan.valid |-> (!result_chan.found_flags[2] || result_chan.found_flags[1]))
		else $error("extra field seen without port field");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> char_chan.ready)
		else $error("empty input register not ready");
`endif

endmodule

// File: sv/hptp_step.sv
// Per-character parse step: next parser state and the result on a terminator.
module hptp_step import hptp_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   char_code,
	input  logic         extra_en,
	output parse_state_t nxt,
	output result_t      res,
	output logic         fire
);

	always_comb begin
		res.host_address = cur.addr;
		res.port_number  = cur.port;
		res.extra_number = cur.extra;
		res.found_flags  = {cur.seen[1], cur.seen[0], (cur.addr != 32'd0)};
		fire             = (char_code == CH_NUL);
	end

	always_comb begin
		phase_t      p;
		logic [11:0] mac;
		nxt = cur;
		p   = cur.phase;
		mac = 12'(cur.addr[7:0]) * 12'd10 + 12'(char_code[3:0]);

		if (fire) begin
			nxt.phase = PH_SKIP;
			nxt.addr  = '0;
			nxt.port  = '0;
			nxt.extra = '0;
			nxt.seen  = '0;
		end else begin
			// first non-blank byte falls through into the address phase
			if (p == PH_SKIP && char_code > CH_SPACE) begin
				p = PH_ADDR;
			end
			if (p == PH_ADDR) begin
				if (is_digit(char_code)) begin
					nxt.addr = {cur.addr[31:8], 8'h00} + 32'(mac);
				end else if (char_code == CH_DOT) begin
					nxt.addr = {cur.addr[23:0], 8'h00};
				end else begin
					p = PH_SEEK;
				end
			end
			nxt.phase = p;
			unique case (p)
				PH_SEEK: begin
					if (char_code == CH_COLON) begin
						nxt.seen[0] = 1'b1;
						nxt.phase   = PH_PORT;
					end
				end
				PH_PORT: begin
					if (is_digit(char_code)) begin
						nxt.port = sat_mac(cur.port, char_code);
					end else if (char_code == CH_COLON && extra_en) begin
						nxt.seen[1] = 1'b1;
						nxt.phase   = PH_EXTRA;
					end else begin
						nxt.phase = PH_IGNORE;
					end
				end
				PH_EXTRA: begin
					if (is_digit(char_code)) begin
						nxt.extra = sat_mac(cur.extra, char_code);
					end else begin
						nxt.phase = PH_IGNORE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/hptp_out_stage.sv
// Result register driving the output channel.
module hptp_out_stage import hptp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  result_t  res,
	output logic     free,
	hptp_result_if.source result_chan
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || result_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result_chan.valid        = valid_q;
	assign result_chan.host_address = res_q.host_address;
	assign result_chan.port_number  = res_q.port_number;
	assign result_chan.extra_number = res_q.extra_number;
	assign result_chan.found_flags  = res_q.found_flags;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the host:port[:extra] text parser.
module testbench;
	import hptp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS = 190;

	logic clk;
	logic arst_n;

	hptp_char_if   char_chan();
	hptp_result_if result_chan();
	hptp_cfg_if    cfg_chan();

	host_port_text_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_chan   (char_chan.sink),
		.result_chan (result_chan.source),
		.cfg_chan    (cfg_chan.sink)
	);

	logic [7:0]   char_backlog[$];
	result_t      expected_results[$];
	result_t      oldest;
	parse_state_t parser = '{phase: PH_SKIP, addr: '0, port: '0, extra: '0, seen: '0};
	logic         extra_enable = 1'b1;

	int  error_count = 0;
	int  idle_cycles = 0;
	int  cfg_writes = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  hold_req = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	bit  char_fired = 1'b0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		char_chan.valid = 1'b0;
		char_chan.char_code = '0;
		result_chan.ready = 1'b0;
		cfg_chan.valid = 1'b0;
		cfg_chan.extra_field_enabled = 1'b1;
		forever #5 clk = ~clk;
	end

	// acc*10 + digit, clamped at the 16-bit maximum
	function automatic logic [15:0] decimal_push(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] wide;
		wide = {4'd0, acc} * 20'd10 + {16'd0, c[3:0]};
		return (wide > {4'd0, NUM_MAX}) ? NUM_MAX : wide[15:0];
	endfunction

	task automatic parse_char(input logic [7:0] c);
		logic        digit;
		logic [7:0]  low;
		logic [11:0] low_next;
		result_t     res;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_NUL) begin
			res.host_address = parser.addr;
			res.port_number = parser.port;
			res.extra_number = parser.extra;
			res.found_flags = {parser.seen[1], parser.seen[0], parser.addr != 32'd0};
			expected_results.push_back(res);
			parser = '{phase: PH_SKIP, addr: '0, port: '0, extra: '0, seen: '0};
			return;
		end
		if (parser.phase == PH_SKIP) begin
			if (c <= CH_SPACE)
				return;
			parser.phase = PH_ADDR;
		end
		if (parser.phase == PH_ADDR) begin
			if (digit) begin
				low = parser.addr[7:0];
				low_next = {4'd0, low} * 12'd10 + {8'd0, c[3:0]};
				parser.addr = parser.addr - {24'd0, low} + {20'd0, low_next};
				return;
			end
			if (c == CH_DOT) begin
				parser.addr = parser.addr << 8;
				return;
			end
			parser.phase = PH_SEEK;
		end
		case (parser.phase)
			PH_SEEK: begin
				if (c == CH_COLON) begin
					parser.seen[0] = 1'b1;
					parser.phase = PH_PORT;
				end
			end
			PH_PORT: begin
				if (digit) begin
					parser.port = decimal_push(parser.port, c);
				end else if (c == CH_COLON && extra_enable) begin
					parser.seen[1] = 1'b1;
					parser.phase = PH_EXTRA;
				end else begin
					parser.phase = PH_IGNORE;
				end
			end
			PH_EXTRA: begin
				if (digit)
					parser.extra = decimal_push(parser.extra, c);
				else
					parser.phase = PH_IGNORE;
			end
			default: ;
		endcase
	endtask

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Sampling side: handshakes, prediction, checking, watchdog.
	always @(posedge clk) begin
		char_fired = char_chan.valid && char_chan.ready;
		if (arst_n) begin
			if (char_fired) begin
				parse_char(char_chan.char_code);
				void'(char_backlog.pop_front());
			end
			if (result_chan.valid && result_chan.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", result_chan.host_address, 32'd0);
				end else begin
					oldest = expected_results.pop_front();
					if (result_chan.host_address !== oldest.host_address)
						report_mismatch("host_address", result_chan.host_address,
							oldest.host_address);
					if (result_chan.port_number !== oldest.port_number)
						report_mismatch("port_number", {16'd0, result_chan.port_number},
							{16'd0, oldest.port_number});
					if (result_chan.extra_number !== oldest.extra_number)
						report_mismatch("extra_number", {16'd0, result_chan.extra_number},
							{16'd0, oldest.extra_number});
					if (result_chan.found_flags !== oldest.found_flags)
						report_mismatch("found_flags", {29'd0, result_chan.found_flags},
							{29'd0, oldest.found_flags});
				end
			end
			if (cfg_chan.valid && cfg_chan.ready) begin
				extra_enable = cfg_chan.extra_field_enabled;
				cfg_writes++;
			end
			if (char_fired || (result_chan.valid && result_chan.ready) ||
					(cfg_chan.valid && cfg_chan.ready))
				idle_cycles = 0;
			else if (char_backlog.size() > 0 || expected_results.size() > 0 || cfg_chan.valid)
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Character sender: holds an offered item until it is taken.
	always @(negedge clk) begin
		if (!arst_n || !(char_chan.valid && !char_fired)) begin
			if (arst_n && char_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				char_chan.valid <= 1'b1;
				char_chan.char_code <= char_backlog[0];
			end else begin
				char_chan.valid <= 1'b0;
			end
		end
	end

	// Result receiver, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_req != hold_served) begin
			hold_served <= hold_req;
			hold_left <= HOLD_OFF_CYCLES;
			result_chan.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_chan.ready <= 1'b0;
		end else begin
			result_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			char_backlog.push_back(s[i]);
		char_backlog.push_back(CH_NUL);
	endtask

	// Mostly well-formed strings with random content, some corrupted, some noise; in short mode also bare terminators.
	task automatic queue_random_string(input bit short_mode);
		int kind;
		int n;
		int octets;
		logic [7:0] text[$];
		kind = $urandom_range(99);
		if (short_mode && kind < 50) begin
			// bare terminator
		end else if (kind < 10) begin
			n = $urandom_range(8);
			repeat (n) text.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(3)) text.push_back(8'($urandom_range(1, 32)));
			octets = $urandom_range(1, 4);
			for (int o = 0; o < octets; o++) begin
				if (o > 0) text.push_back(CH_DOT);
				n = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
				repeat (n) text.push_back(rand_digit());
			end
			if ($urandom_range(9) < 8) begin
				text.push_back(CH_COLON);
				repeat ($urandom_range(6)) text.push_back(rand_digit());
				if ($urandom_range(9) < 6) begin
					text.push_back(CH_COLON);
					repeat ($urandom_range(6)) text.push_back(rand_digit());
				end
			end
			if ($urandom_range(9) < 2)
				repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(1, 255)));
			if (kind < 25)
				text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
		end
		foreach (text[i]) char_backlog.push_back(text[i]);
		char_backlog.push_back(CH_NUL);
	endtask

	task automatic run_phase(input logic enable, input int send_pct, input int recv_pct,
			input bit pressure);
		int seen_writes;
		int start_size;
		wait (char_backlog.size() == 0 && expected_results.size() == 0);
		repeat (5) @(posedge clk);
		seen_writes = cfg_writes;
		@(negedge clk);
		cfg_chan.extra_field_enabled <= enable;
		cfg_chan.valid <= 1'b1;
		wait (cfg_writes != seen_writes);
		@(negedge clk);
		cfg_chan.valid <= 1'b0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (pressure) hold_req++;
		start_size = char_backlog.size();
		while (char_backlog.size() - start_size < PHASE_ITEMS)
			queue_random_string(pressure);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty string, skipped control byte, address wrap, port
		// saturation, high byte ending the address, non-colon after the port
		queue_text("");
		char_backlog.push_back(8'h01);
		queue_text("999.9:99999:7");
		char_backlog.push_back(CH_SPACE);
		char_backlog.push_back(8'hFF);
		queue_text(":5");
		queue_text("1:2x");

		run_phase(1'b1, 0, 0, 1'b0);
		run_phase(1'b0, 47, 0, 1'b0);
		run_phase(1'b1, 0, 47, 1'b0);
		run_phase(1'b0, 27, 27, 1'b0);
		run_phase(1'b1, 0, 0, 1'b1);

		wait (char_backlog.size() == 0 && expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
sv/hptp_pkg.sv
sv/hptp_ifs.sv
sv/hptp_step.sv
sv/hptp_out_stage.sv
sv/host_port_text_parser.sv
dv/testbench.sv
